[design/fdp_pkg.sv]
// ----------------------------------------------------------------------------
// fdp_pkg
// Shared widths, reset values, register map and types for the frame delta
// pacer.
// ----------------------------------------------------------------------------
package fdp_pkg;

  // field widths
  localparam int TS_W    = 64;  // timestamp
  localparam int CFG_W   = 32;  // configuration registers
  localparam int DELTA_W = 35;  // frame delta, history entries, leftover
  localparam int ACC_W   = 36;  // accumulator
  localparam int CNT_W   = 4;   // update counts
  localparam int PER_W   = 34;  // snap period, up to four times the base

  // configuration port
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 2;

  localparam logic [REG_IDX_W-1:0] REG_FRAME_PERIOD    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_VSYNC_TOLERANCE = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SNAP_BASE       = 2'd2;

  // reset values
  localparam logic [CFG_W-1:0]   FRAME_PERIOD_RST    = 32'd16666;
  localparam logic [CFG_W-1:0]   VSYNC_TOLERANCE_RST = 32'd200;
  localparam logic [CFG_W-1:0]   SNAP_BASE_RST       = 32'd16666;
  localparam logic [DELTA_W-1:0] HIST_RST            = 35'd16666;

  // pacing constants
  localparam int MAX_PASSES    = 8;  // cap on update loop passes
  localparam int DEFINED_SNAPS = 5;  // base multiples plus the half period
  localparam int SNAP_MULTS    = 4;  // base, 2x, 3x, 4x
  localparam int SNAP_IW       = 3;  // index over the defined snap periods
  localparam int DIV_STEP_BITS = 8;  // quotient bits per divider cycle

  // parameter defaults
  localparam int HISTORY_DEPTH_DEF = 4;
  localparam int SNAP_COUNT_DEF    = 5;

  typedef struct packed {
    logic [CFG_W-1:0] frame_period;
    logic [CFG_W-1:0] vsync_tolerance;
    logic [CFG_W-1:0] snap_base;
  } cfg_t;

endpackage

[design/frame_delta_pacer.sv]
// Sequence: from an input transaction to out_valid the engine steps through the delta state,
//   the snap search (one snap period per cycle), the history update, the mean divider, the
//   accumulate state and the update loop (one pass per cycle, at most eight) plus an exit.
// Flow: a transaction is taken only once the last one is done; in_ready is high only in idle.
//   A result waits in the output register; the next one holds in the update loop until taken.
// Reset: synchronous rst_n restores defaults, fills the history with 16666, clears acc/last.
// ----------------------------------------------------------------------------
// frame_delta_pacer
// Fixed-timestep frame pacing with vsync snapping: per frame timestamp,
// reports fixed updates, extra variable updates, leftover delta and the
// accumulator remainder.
// ----------------------------------------------------------------------------
module frame_delta_pacer #(
  parameter int HISTORY_DEPTH = fdp_pkg::HISTORY_DEPTH_DEF,
  parameter int SNAP_COUNT    = fdp_pkg::SNAP_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [fdp_pkg::TS_W-1:0]       in_timestamp,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [fdp_pkg::CNT_W-1:0]      out_fixed_updates,
  output logic [fdp_pkg::CNT_W-1:0]      out_extra_variable_updates,
  output logic [fdp_pkg::DELTA_W-1:0]    out_leftover_delta,
  output logic [fdp_pkg::CFG_W-1:0]      out_accumulator_left,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fdp_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [fdp_pkg::APB_DATA_W-1:0] pwdata,
  output logic [fdp_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import fdp_pkg::*;

  cfg_t cfg;

  // configuration registers
  fdp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // pacing sequencer and datapath
  fdp_engine #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .SNAP_COUNT    (SNAP_COUNT)
  ) u_engine (
    .clk                        (clk),
    .rst_n                      (rst_n),
    .cfg                        (cfg),
    .in_valid                   (in_valid),
    .in_ready                   (in_ready),
    .in_timestamp               (in_timestamp),
    .out_valid                  (out_valid),
    .out_ready                  (out_ready),
    .out_fixed_updates          (out_fixed_updates),
    .out_extra_variable_updates (out_extra_variable_updates),
    .out_leftover_delta         (out_leftover_delta),
    .out_accumulator_left       (out_accumulator_left)
  );

endmodule

[design/fdp_cfg.sv]
// ----------------------------------------------------------------------------
// fdp_cfg
// APB-style configuration registers: frame period, vsync tolerance and snap
// base. Zero wait states, full read-back.
// ----------------------------------------------------------------------------
module fdp_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fdp_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [fdp_pkg::APB_DATA_W-1:0] pwdata,
  output logic [fdp_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  output fdp_pkg::cfg_t                  cfg
);
  import fdp_pkg::*;

  logic [CFG_W-1:0]     frame_period_r;
  logic [CFG_W-1:0]     vsync_tolerance_r;
  logic [CFG_W-1:0]     snap_base_r;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite;

  // register writes on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_period_r    <= FRAME_PERIOD_RST;
      vsync_tolerance_r <= VSYNC_TOLERANCE_RST;
      snap_base_r       <= SNAP_BASE_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_FRAME_PERIOD:    frame_period_r    <= pwdata;
        REG_VSYNC_TOLERANCE: vsync_tolerance_r <= pwdata;
        REG_SNAP_BASE:       snap_base_r       <= pwdata;
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      REG_FRAME_PERIOD:    prdata = frame_period_r;
      REG_VSYNC_TOLERANCE: prdata = vsync_tolerance_r;
      REG_SNAP_BASE:       prdata = snap_base_r;
      default:             prdata = '0;
    endcase
  end

  assign cfg.frame_period    = frame_period_r;
  assign cfg.vsync_tolerance = vsync_tolerance_r;
  assign cfg.snap_base       = snap_base_r;

endmodule

[design/fdp_div.sv]
// ----------------------------------------------------------------------------
// fdp_div
// Iterative restoring divider by a constant: STEP_BITS quotient bits per cycle
// on a narrow remainder. Used for the history mean.
// ----------------------------------------------------------------------------
module fdp_div #(
  parameter int DIVISOR   = fdp_pkg::HISTORY_DEPTH_DEF,
  parameter int IN_W      = fdp_pkg::DELTA_W,
  parameter int STEP_BITS = fdp_pkg::DIV_STEP_BITS
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [IN_W-1:0] dividend,
  output logic            done,
  output logic [IN_W-1:0] quotient
);
  localparam int DIV_CYC = (IN_W + STEP_BITS - 1) / STEP_BITS;
  localparam int PAD_W   = DIV_CYC * STEP_BITS;
  localparam int REM_W   = $clog2(DIVISOR) + 1;
  localparam int CYC_W   = $clog2(DIV_CYC + 1);
  localparam logic [REM_W:0] DIV_K = (REM_W + 1)'(DIVISOR);

  logic [PAD_W-1:0] q_r, q_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [CYC_W-1:0] cyc_r;
  logic             run_r;
  logic             done_r;
  logic [REM_W:0]   rem_x;

  // STEP_BITS restoring steps; dividend bits shift out the top of q,
  // quotient bits shift in at the bottom
  always_comb begin
    q_nxt   = q_r;
    rem_nxt = rem_r;
    rem_x   = '0;
    for (int i = 0; i < STEP_BITS; i++) begin
      rem_x = {rem_nxt, q_nxt[PAD_W-1]};
      q_nxt = {q_nxt[PAD_W-2:0], 1'b0};
      if (rem_x >= DIV_K) begin
        rem_x    = rem_x - DIV_K;
        q_nxt[0] = 1'b1;
      end
      rem_nxt = rem_x[REM_W-1:0];
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && cyc_r == CYC_W'(DIV_CYC - 1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= PAD_W'(dividend);
      rem_r <= '0;
      cyc_r <= '0;
    end else if (run_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
      cyc_r <= cyc_r + 1'b1;
    end
  end

  assign done     = done_r;
  assign quotient = q_r[IN_W-1:0];

endmodule

[design/fdp_engine.sv]
// ----------------------------------------------------------------------------
// fdp_engine
// Sequencer and shared subtract/compare unit: frame delta, clamp, vsync
// snap search, history update, accumulator and the fixed update loop.
// ----------------------------------------------------------------------------
module fdp_engine #(
  parameter int HISTORY_DEPTH = fdp_pkg::HISTORY_DEPTH_DEF,
  parameter int SNAP_COUNT    = fdp_pkg::SNAP_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  fdp_pkg::cfg_t               cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [fdp_pkg::TS_W-1:0]    in_timestamp,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [fdp_pkg::CNT_W-1:0]   out_fixed_updates,
  output logic [fdp_pkg::CNT_W-1:0]   out_extra_variable_updates,
  output logic [fdp_pkg::DELTA_W-1:0] out_leftover_delta,
  output logic [fdp_pkg::CFG_W-1:0]   out_accumulator_left
);
  import fdp_pkg::*;

  localparam int N_SNAP = (SNAP_COUNT < DEFINED_SNAPS) ? SNAP_COUNT : DEFINED_SNAPS;
  localparam int SUM_W  = DELTA_W + $clog2(HISTORY_DEPTH);
  localparam logic [SUM_W-1:0] SUM_RST = SUM_W'(HISTORY_DEPTH * 16666);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DELTA = 3'd1;
  localparam logic [2:0] S_SNAP  = 3'd2;
  localparam logic [2:0] S_HIST  = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_ACC   = 3'd5;
  localparam logic [2:0] S_LOOP  = 3'd6;

  logic [2:0]         state_r, state_nxt;
  logic [TS_W-1:0]    ts_r, ts_nxt;
  logic [TS_W-1:0]    last_r, last_nxt;
  logic [DELTA_W-1:0] delta_r, delta_nxt;
  logic [PER_W-1:0]   per_r, per_nxt;
  logic [SNAP_IW-1:0] snap_r, snap_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic               resync_r, resync_nxt;
  logic [CNT_W-1:0]   fixed_r, fixed_nxt;
  logic [CNT_W-1:0]   extra_r, extra_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_load;
  logic [DELTA_W-1:0] hist_r [HISTORY_DEPTH];

  logic [CNT_W-1:0]   out_fixed_r;
  logic [CNT_W-1:0]   out_extra_r;
  logic [DELTA_W-1:0] out_left_r;
  logic [CFG_W-1:0]   out_acc_r;

  // shared subtract/compare unit
  logic [TS_W-1:0]    alu_a, alu_b;
  logic [TS_W:0]      alu_diff;
  logic               alu_borrow;

  logic [DELTA_W-1:0] limit;
  logic [DELTA_W-1:0] fp35;
  logic               delta_ge_per;
  logic [CFG_W:0]     snap_half;
  logic [ACC_W-1:0]   acc_sum;
  logic [DELTA_W-1:0] mean;
  logic               div_start;
  logic               div_done;
  logic [SUM_W-1:0]   div_quot;

  assign limit        = {cfg.frame_period, 3'b000};
  assign fp35         = DELTA_W'(cfg.frame_period);
  assign delta_ge_per = (delta_r >= DELTA_W'(per_r));
  assign snap_half    = ({1'b0, cfg.snap_base} + (CFG_W + 1)'(1)) >> 1;
  assign mean         = div_quot[DELTA_W-1:0];
  assign acc_sum      = acc_r + ACC_W'(mean);
  assign div_start    = (state_r == S_HIST);

  // operand select for the shared unit
  always_comb begin
    alu_a = '0;
    alu_b = '0;
    case (state_r)
      S_DELTA: begin
        alu_a = ts_r;
        alu_b = last_r;
      end
      S_SNAP: begin
        if (delta_ge_per) begin
          alu_a = TS_W'(delta_r);
          alu_b = TS_W'(per_r);
        end else begin
          alu_a = TS_W'(per_r);
          alu_b = TS_W'(delta_r);
        end
      end
      S_LOOP: begin
        alu_a = TS_W'(acc_r);
        alu_b = TS_W'(cfg.frame_period);
      end
      default: ;
    endcase
  end

  assign alu_diff   = {1'b0, alu_a} - {1'b0, alu_b};
  assign alu_borrow = alu_diff[TS_W];

  // mean of the history; the divider loads the updated running sum
  fdp_div #(
    .DIVISOR   (HISTORY_DEPTH),
    .IN_W      (SUM_W),
    .STEP_BITS (DIV_STEP_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_nxt),
    .done     (div_done),
    .quotient (div_quot)
  );

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    ts_nxt     = ts_r;
    last_nxt   = last_r;
    delta_nxt  = delta_r;
    per_nxt    = per_r;
    snap_nxt   = snap_r;
    sum_nxt    = sum_r;
    acc_nxt    = acc_r;
    resync_nxt = resync_r;
    fixed_nxt  = fixed_r;
    extra_nxt  = extra_r;
    out_load   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ts_nxt    = in_timestamp;
          state_nxt = S_DELTA;
        end
      end
      // signed frame delta, clamp timer anomalies
      S_DELTA: begin
        last_nxt = ts_r;
        if (alu_diff[TS_W-1]) begin
          delta_nxt = '0;
        end else if (alu_diff[TS_W-1:0] > TS_W'(limit)) begin
          delta_nxt = fp35;
        end else begin
          delta_nxt = alu_diff[DELTA_W-1:0];
        end
        per_nxt   = PER_W'(cfg.snap_base);
        snap_nxt  = '0;
        state_nxt = S_SNAP;
      end
      // one snap period per cycle, first match wins
      S_SNAP: begin
        if (alu_diff[DELTA_W-1:0] < DELTA_W'(cfg.vsync_tolerance)) begin
          delta_nxt = DELTA_W'(per_r);
          state_nxt = S_HIST;
        end else if (snap_r == SNAP_IW'(N_SNAP - 1)) begin
          state_nxt = S_HIST;
        end else begin
          snap_nxt = snap_r + 1'b1;
          if (snap_r == SNAP_IW'(SNAP_MULTS - 1)) begin
            per_nxt = PER_W'(snap_half);
          end else begin
            per_nxt = per_r + PER_W'(cfg.snap_base);
          end
        end
      end
      // running sum tracks the history contents
      S_HIST: begin
        sum_nxt   = sum_r - SUM_W'(hist_r[0]) + SUM_W'(delta_r);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_ACC;
        end
      end
      // accumulate, resync on overflow or first frame
      S_ACC: begin
        if ((acc_sum > ACC_W'(limit)) || resync_r) begin
          acc_nxt    = '0;
          delta_nxt  = fp35;
          resync_nxt = 1'b0;
        end else begin
          acc_nxt   = acc_sum;
          delta_nxt = mean;
        end
        fixed_nxt = '0;
        extra_nxt = '0;
        state_nxt = S_LOOP;
      end
      // one fixed update per cycle
      S_LOOP: begin
        if (!alu_borrow && (fixed_r < CNT_W'(MAX_PASSES))) begin
          fixed_nxt = fixed_r + 1'b1;
          if (delta_r > fp35) begin
            extra_nxt = extra_r + 1'b1;
            delta_nxt = delta_r - fp35;
          end
          acc_nxt = alu_diff[ACC_W-1:0];
        end else if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output register handshake
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      last_r      <= '0;
      sum_r       <= SUM_RST;
      acc_r       <= '0;
      resync_r    <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      last_r      <= last_nxt;
      sum_r       <= sum_nxt;
      acc_r       <= acc_nxt;
      resync_r    <= resync_nxt;
    end
  end

  // delta history shift line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist_r[i] <= HIST_RST;
      end
    end else if (state_r == S_HIST) begin
      for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
        hist_r[i] <= hist_r[i+1];
      end
      hist_r[HISTORY_DEPTH-1] <= delta_r;
    end
  end

  // working and result payload
  always_ff @(posedge clk) begin
    ts_r    <= ts_nxt;
    delta_r <= delta_nxt;
    per_r   <= per_nxt;
    snap_r  <= snap_nxt;
    fixed_r <= fixed_nxt;
    extra_r <= extra_nxt;
    if (out_load) begin
      out_fixed_r <= fixed_r;
      out_extra_r <= extra_r;
      out_left_r  <= delta_r;
      out_acc_r   <= acc_r[CFG_W-1:0];
    end
  end

  assign in_ready                   = (state_r == S_IDLE);
  assign out_valid                  = out_valid_r;
  assign out_fixed_updates          = out_fixed_r;
  assign out_extra_variable_updates = out_extra_r;
  assign out_leftover_delta         = out_left_r;
  assign out_accumulator_left       = out_acc_r;

endmodule

[design/fdp_checker.sv]
// ----------------------------------------------------------------------------
// fdp_checker
// Port-level checks for the frame delta pacer, bound to the top level.
// ----------------------------------------------------------------------------
module fdp_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [fdp_pkg::CNT_W-1:0]      out_fixed_updates,
  input logic [fdp_pkg::CNT_W-1:0]      out_extra_variable_updates,
  input logic [fdp_pkg::DELTA_W-1:0]    out_leftover_delta,
  input logic [fdp_pkg::CFG_W-1:0]      out_accumulator_left,
  input logic                           pready
);
  import fdp_pkg::*;

  // an accepted transaction makes the block busy in the following cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready high right after an input transaction");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_fixed_updates)
      && $stable(out_extra_variable_updates) && $stable(out_leftover_delta)
      && $stable(out_accumulator_left)))
    else $error("result changed or dropped while stalled");

  // update counts stay within the loop cap, extra never exceeds fixed
  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_fixed_updates <= CNT_W'(MAX_PASSES))
      && (out_extra_variable_updates <= out_fixed_updates)))
    else $error("update counts out of range");

  // configuration port never inserts wait states
  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    pready)
    else $error("pready low");

endmodule

bind frame_delta_pacer fdp_checker u_fdp_checker (.*);
